// ===== rtl/ble_afl_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_afl_pkg
// Shared types and constants of the BLE advertising field locator.
// ----------------------------------------------------------------------------
package ble_afl_pkg;

  localparam int unsigned ARITH_W  = 9;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 4;

  localparam logic [7:0]  TYPE_SVC16   = 8'h16;
  localparam logic [7:0]  TYPE_SVC32   = 8'h20;
  localparam logic [31:0] UUID16_LIMIT = 32'd65536;

  localparam logic [1:0] REG_MATCH_TYPE       = 2'd0;
  localparam logic [1:0] REG_MATCH_OCCURRENCE = 2'd1;
  localparam logic [1:0] REG_SERVICE_UUID     = 2'd2;
  localparam logic [1:0] REG_SERVICE_MIN_LEN  = 2'd3;

  localparam logic [7:0] MATCH_TYPE_RESET = 8'h0a;

  typedef struct packed {
    logic [7:0]  match_type;
    logic [7:0]  match_occurrence;
    logic [31:0] service_uuid;
    logic [7:0]  service_min_len;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] value;
  } occ_wr_t;

  typedef struct packed {
    logic [7:0] type_count;
    logic       field_found;
    logic [7:0] field_offset;
    logic [7:0] field_length;
    logic       service_found;
    logic [7:0] service_offset;
    logic [7:0] service_length;
  } result_t;

endpackage

// ===== rtl/ble_afl_regs.sv =====
// ----------------------------------------------------------------------------
// ble_afl_regs
// APB-style register file holding the locator configuration.
// ----------------------------------------------------------------------------
module ble_afl_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ble_afl_pkg::ADDR_W-1:0] paddr,
  input  logic [ble_afl_pkg::DATA_W-1:0] pwdata,
  output logic [ble_afl_pkg::DATA_W-1:0] prdata,
  output ble_afl_pkg::cfg_t            cfg,
  output ble_afl_pkg::occ_wr_t         occ_wr
);
  import ble_afl_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;

  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_type       <= MATCH_TYPE_RESET;
      cfg.match_occurrence <= 8'd0;
      cfg.service_uuid     <= 32'd0;
      cfg.service_min_len  <= 8'd0;
    end else if (wr_en) begin
      case (reg_index)
        REG_MATCH_TYPE:       cfg.match_type       <= pwdata[7:0];
        REG_MATCH_OCCURRENCE: cfg.match_occurrence <= pwdata[7:0];
        REG_SERVICE_UUID:     cfg.service_uuid     <= pwdata;
        REG_SERVICE_MIN_LEN:  cfg.service_min_len  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // the parser reloads its occurrence counter only between payloads
  assign occ_wr.en    = wr_en && (reg_index == REG_MATCH_OCCURRENCE);
  assign occ_wr.value = pwdata[7:0];

  always_comb begin
    case (reg_index)
      REG_MATCH_TYPE:       prdata = {24'd0, cfg.match_type};
      REG_MATCH_OCCURRENCE: prdata = {24'd0, cfg.match_occurrence};
      REG_SERVICE_UUID:     prdata = cfg.service_uuid;
      REG_SERVICE_MIN_LEN:  prdata = {24'd0, cfg.service_min_len};
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ble_afl_parser.sv =====
// ----------------------------------------------------------------------------
// ble_afl_parser
// Per-byte length-type-data walker; closes structures and builds the result.
// ----------------------------------------------------------------------------
module ble_afl_parser #(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  ble_afl_pkg::cfg_t    cfg,
  input  ble_afl_pkg::occ_wr_t occ_wr,
  output ble_afl_pkg::result_t result
);
  import ble_afl_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] struct_start, struct_start_next;
  logic [7:0]       struct_bytes_left, struct_bytes_left_next;
  logic [7:0]       struct_type, struct_type_next;
  logic [31:0]      uuid_shift, uuid_shift_next;
  logic [7:0]       occurrences_left, occurrences_left_next;
  logic [7:0]       count_reg, count_reg_next;
  logic             field_hit, field_hit_next;
  logic [7:0]       field_hit_offset, field_hit_offset_next;
  logic [7:0]       field_hit_length, field_hit_length_next;
  logic             service_hit, service_hit_next;
  logic [7:0]       service_hit_offset, service_hit_offset_next;
  logic [7:0]       service_hit_length, service_hit_length_next;

  logic               active;
  logic [POS_W-1:0]   k;
  logic               closed_inline;
  logic               close_en;
  logic [ARITH_W-1:0] slen;
  logic [ARITH_W-1:0] start_ext;
  logic [ARITH_W-1:0] min_ext;
  logic [15:0]        uuid16;
  logic               type_match;

  always_comb begin
    active                 = byte_position < POS_W'(MAX_PAYLOAD);
    byte_position_next     = byte_position;
    struct_start_next      = struct_start;
    struct_bytes_left_next = struct_bytes_left;
    struct_type_next       = struct_type;
    uuid_shift_next        = uuid_shift;
    closed_inline          = 1'b0;
    k                      = byte_position - struct_start - POS_W'(1);

    if (active) begin
      byte_position_next = byte_position + POS_W'(1);
      if (struct_bytes_left == 8'd0) begin
        struct_start_next      = byte_position;
        struct_bytes_left_next = data_byte;
        struct_type_next       = 8'd0;
        uuid_shift_next        = 32'd0;
      end else begin
        case (k)
          POS_W'(0): struct_type_next        = data_byte;
          POS_W'(1): uuid_shift_next[7:0]    = data_byte;
          POS_W'(2): uuid_shift_next[15:8]   = data_byte;
          POS_W'(3): uuid_shift_next[23:16]  = data_byte;
          POS_W'(4): uuid_shift_next[31:24]  = data_byte;
          default: ;
        endcase
        struct_bytes_left_next = struct_bytes_left - 8'd1;
        closed_inline          = (struct_bytes_left == 8'd1);
      end
    end

    // a structure still open at the last byte closes with what arrived
    close_en  = closed_inline || (last_byte && (struct_bytes_left_next != 8'd0));
    start_ext = ARITH_W'(struct_start_next);
    slen      = ARITH_W'(byte_position_next) - start_ext;
    min_ext   = ARITH_W'(cfg.service_min_len);
    uuid16    = (cfg.service_uuid < UUID16_LIMIT) ? cfg.service_uuid[15:0] : 16'd0;
    type_match = struct_type_next == cfg.match_type;

    count_reg_next          = count_reg;
    occurrences_left_next   = occurrences_left;
    field_hit_next          = field_hit;
    field_hit_offset_next   = field_hit_offset;
    field_hit_length_next   = field_hit_length;
    service_hit_next        = service_hit;
    service_hit_offset_next = service_hit_offset;
    service_hit_length_next = service_hit_length;

    if (close_en && (slen >= ARITH_W'(2))) begin
      if (type_match) begin
        if (count_reg != 8'hff) begin
          count_reg_next = count_reg + 8'd1;
        end
        if (!field_hit) begin
          if (occurrences_left == 8'd0) begin
            field_hit_next        = 1'b1;
            field_hit_offset_next = 8'(start_ext + ARITH_W'(2));
            field_hit_length_next = 8'(slen - ARITH_W'(2));
          end else begin
            occurrences_left_next = occurrences_left - 8'd1;
          end
        end
      end
      if (!service_hit) begin
        if ((struct_type_next == TYPE_SVC16) && (slen >= min_ext + ARITH_W'(4)) &&
            (uuid_shift_next[15:0] == uuid16)) begin
          service_hit_next        = 1'b1;
          service_hit_offset_next = 8'(start_ext + ARITH_W'(4));
          service_hit_length_next = 8'(slen - ARITH_W'(4));
        end else if ((struct_type_next == TYPE_SVC32) &&
                     (slen >= min_ext + ARITH_W'(6)) &&
                     (uuid_shift_next == cfg.service_uuid)) begin
          service_hit_next        = 1'b1;
          service_hit_offset_next = 8'(start_ext + ARITH_W'(6));
          service_hit_length_next = 8'(slen - ARITH_W'(6));
        end
      end
    end

    result.type_count     = count_reg_next;
    result.field_found    = field_hit_next;
    result.field_offset   = field_hit_next ? field_hit_offset_next : 8'd0;
    result.field_length   = field_hit_next ? field_hit_length_next : 8'd0;
    result.service_found  = service_hit_next;
    result.service_offset = service_hit_next ? service_hit_offset_next : 8'd0;
    result.service_length = service_hit_next ? service_hit_length_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_position      <= '0;
      struct_start       <= '0;
      struct_bytes_left  <= 8'd0;
      struct_type        <= 8'd0;
      uuid_shift         <= 32'd0;
      occurrences_left   <= rst ? 8'd0 : cfg.match_occurrence;
      count_reg          <= 8'd0;
      field_hit          <= 1'b0;
      field_hit_offset   <= 8'd0;
      field_hit_length   <= 8'd0;
      service_hit        <= 1'b0;
      service_hit_offset <= 8'd0;
      service_hit_length <= 8'd0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      struct_start       <= struct_start_next;
      struct_bytes_left  <= struct_bytes_left_next;
      struct_type        <= struct_type_next;
      uuid_shift         <= uuid_shift_next;
      occurrences_left   <= occurrences_left_next;
      count_reg          <= count_reg_next;
      field_hit          <= field_hit_next;
      field_hit_offset   <= field_hit_offset_next;
      field_hit_length   <= field_hit_length_next;
      service_hit        <= service_hit_next;
      service_hit_offset <= service_hit_offset_next;
      service_hit_length <= service_hit_length_next;
    end else if (occ_wr.en && (byte_position == '0)) begin
      occurrences_left <= occ_wr.value;
    end
  end

endmodule

// ===== rtl/ble_adv_field_locator.sv =====
// ----------------------------------------------------------------------------
// ble_adv_field_locator
// Streaming locator for the length-type-data structures of a BLE payload.
// ----------------------------------------------------------------------------
// Usage:
//   Payload bytes enter on the byte channel (data_byte, last_byte) with a
//   valid/ready handshake, one byte per cycle. Each byte is parsed in the
//   cycle it is accepted. The byte marked last_byte produces one request on
//   the result channel, registered: it shows on the result ports in the cycle
//   after that byte is accepted. All other bytes produce nothing.
//   Throughput is one byte per cycle; the only stall source is the result
//   register. byte_ready stays high while that register is empty or is
//   being drained in the same cycle, so a held result blocks new bytes only
//   while result_ready is low.
//   Configuration goes through the APB port: match_type at 0x0, 
//   match_occurrence at 0x4, service_uuid at 0x8, service_min_len at 0xC.
//   A match_occurrence write reloads the occurrence counter only between
//   payloads.
//   Synchronous reset empties the result register, clears all payload
//   state and loads the register reset values.
// ----------------------------------------------------------------------------
module ble_adv_field_locator #(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ble_afl_pkg::ADDR_W-1:0] paddr,
  input  logic [ble_afl_pkg::DATA_W-1:0] pwdata,
  output logic [ble_afl_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           byte_valid,
  output logic                           byte_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [7:0]                     type_count,
  output logic                           field_found,
  output logic [7:0]                     field_offset,
  output logic [7:0]                     field_length,
  output logic                           service_found,
  output logic [7:0]                     service_offset,
  output logic [7:0]                     service_length
);
  import ble_afl_pkg::*;

  cfg_t    cfg;
  occ_wr_t occ_wr;
  result_t result;
  result_t result_q;
  logic    accept;

  assign pready     = 1'b1;
  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  ble_afl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .occ_wr  (occ_wr)
  );

  ble_afl_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (cfg),
    .occ_wr    (occ_wr),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      result_q <= result;
    end
  end

  assign type_count     = result_q.type_count;
  assign field_found    = result_q.field_found;
  assign field_offset   = result_q.field_offset;
  assign field_length   = result_q.field_length;
  assign service_found  = result_q.service_found;
  assign service_offset = result_q.service_offset;
  assign service_length = result_q.service_length;

endmodule
